// ===== hdl/cgr_pkg.sv =====
// Shared types and constants for the colour gradient ramp.
package cgr_pkg;

    localparam int MAX_STOPS     = 16;
    localparam int IDX_W         = $clog2(MAX_STOPS);
    localparam int CNT_W         = $clog2(MAX_STOPS + 1);
    localparam int FRACTION_BITS = 16;
    localparam int POS_W         = 17;
    localparam int COLOR_W       = 32;
    localparam int QDIV_W        = POS_W + FRACTION_BITS;
    localparam int T_W           = FRACTION_BITS + 1;

    localparam logic [COLOR_W-1:0] OPAQUE_BLACK = 32'h0000_00FF;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [POS_W-1:0]   position;
        logic [COLOR_W-1:0] color;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color_out;
        logic [1:0]         status;
        logic [4:0]         stops_held;
    } out_item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLAMP,
        BK_SEARCH,
        BK_DIVIDE,
        BK_BLEND,
        BK_OUT
    } bk_state_t;

    // front-to-back job
    typedef struct packed {
        logic               lookup;
        logic [POS_W-1:0]   position;
        logic [COLOR_W-1:0] color_out;
        logic [1:0]         status;
        logic [4:0]         stops_held;
        logic [CNT_W-1:0]   count;
    } job_t;

endpackage

// ===== hdl/cgr_front.sv =====
// Front: accept transfers, maintain the stop table and count, classify jobs.
module cgr_front import cgr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output logic               job_valid,
    input  logic               job_stall,
    output job_t               job,
    input  logic               back_busy,
    input  logic [IDX_W-1:0]   rd_idx,
    output logic [POS_W-1:0]   rd_pos,
    output logic [COLOR_W-1:0] rd_color
);

    logic [POS_W-1:0]   pos_mem [MAX_STOPS];
    logic [COLOR_W-1:0] col_mem [MAX_STOPS];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               take;
    logic               wr_en;
    logic               clear_hold;
    job_t               job_c;

    // hold a clear until no earlier lookup can still read the table
    assign clear_hold = (in_data.command == CMD_CLEAR) && back_busy;
    assign in_stall   = job_stall || clear_hold;
    assign take       = in_valid && !in_stall;
    assign wr_en      = take && (in_data.command == CMD_ADD) &&
                        (count_reg < CNT_W'(MAX_STOPS));

    always_comb
    begin
        count_next      = count_reg;
        job_c           = '0;
        job_c.position  = in_data.position;
        job_c.count     = count_reg;
        unique case (cmd_t'(in_data.command))
            CMD_ADD:
            begin
                if (count_reg < CNT_W'(MAX_STOPS))
                    count_next = count_reg + 1'b1;
                else
                    job_c.status = ST_FULL;
            end
            CMD_CLEAR:  count_next = '0;
            CMD_LOOKUP:
            begin
                if (count_reg == '0)
                begin
                    job_c.color_out = OPAQUE_BLACK;
                    job_c.status    = ST_EMPTY;
                end
                else
                    job_c.lookup = 1'b1;
            end
            CMD_NONE:   ;
            default:    ;
        endcase
        job_c.stops_held = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (take)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[count_reg[IDX_W-1:0]] <= in_data.position;
            col_mem[count_reg[IDX_W-1:0]] <= in_data.color;
        end
        rd_pos   <= pos_mem[rd_idx];
        rd_color <= col_mem[rd_idx];
    end

    assign job_valid = in_valid && !clear_hold;
    assign job       = job_c;

endmodule

// ===== hdl/cgr_queue.sv =====
// Two-entry job queue between front and back.
module cgr_queue import cgr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_stall,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_take,
    output job_t rd_data
);

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_take && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

// ===== hdl/cgr_back.sv =====
// Back: segment search, iterative fraction division and channel blend.
module cgr_back import cgr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_take,
    input  job_t               job,
    output logic               idle,
    output logic [IDX_W-1:0]   rd_idx,
    input  logic [POS_W-1:0]   rd_pos,
    input  logic [COLOR_W-1:0] rd_color,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data
);

    bk_state_t          state_reg, state_next;
    job_t               job_reg;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [1:0]         ph_reg, ph_next;
    logic [POS_W-1:0]   p0_reg, first_pos_reg;
    logic [COLOR_W-1:0] c0_reg, first_col_reg, res_reg, res_next;
    logic [POS_W-1:0]   d_reg;
    logic [QDIV_W:0]    rem_reg;
    logic [QDIV_W-1:0]  quo_reg;
    logic [5:0]         bit_reg;
    logic [T_W-1:0]     t_reg;
    logic [COLOR_W-1:0] c1_reg;
    logic               ld_job, cap_c0, cap_first, cap_c1, div_init, div_step, set_t;
    logic [QDIV_W:0]    rem_sh;
    logic [POS_W-1:0]   num;
    logic [QDIV_W-1:0]  t_full;
    logic [COLOR_W-1:0] blend_c;

    assign num    = job_reg.position - p0_reg;
    assign rem_sh = {rem_reg[QDIV_W-1:0], quo_reg[QDIV_W-1]};
    assign t_full = quo_reg;

    always_comb
    begin
        logic [8:0]  a, b;
        logic [T_W:0] omt;
        logic [FRACTION_BITS+9:0] v;
        blend_c = '0;
        omt     = (T_W+1)'(1 << FRACTION_BITS) - {1'b0, t_reg};
        for (int k = 0; k < 4; k++)
        begin
            a = {1'b0, c0_reg[8*k +: 8]};
            b = {1'b0, c1_reg[8*k +: 8]};
            v = (FRACTION_BITS+10)'(a) * (FRACTION_BITS+10)'(omt)
                + (FRACTION_BITS+10)'(b) * (FRACTION_BITS+10)'(t_reg)
                + (FRACTION_BITS+10)'(1 << (FRACTION_BITS-1));
            blend_c[8*k +: 8] = (v[FRACTION_BITS+9:FRACTION_BITS] > 10'd255) ?
                                8'hFF : v[FRACTION_BITS+7:FRACTION_BITS];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        ph_next    = ph_reg;
        res_next   = res_reg;
        ld_job = 1'b0; cap_c0 = 1'b0; cap_first = 1'b0; cap_c1 = 1'b0;
        div_init = 1'b0; div_step = 1'b0; set_t = 1'b0;
        rd_idx   = i_reg[IDX_W-1:0];
        job_take = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_take = 1'b1;
                    ld_job   = 1'b1;
                    res_next = job.color_out;
                    ph_next  = 2'd0;
                    i_next   = '0;
                    state_next = job.lookup ? BK_CLAMP : BK_OUT;
                end
            end
            BK_CLAMP:
            begin
                // phase 0 read first, phase 1 capture first and read last
                unique case (ph_reg)
                    2'd0:
                    begin
                        rd_idx  = '0;
                        ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        cap_first = 1'b1;
                        rd_idx    = IDX_W'(job_reg.count - 1'b1);
                        ph_next   = 2'd2;
                    end
                    default:
                    begin
                        if (job_reg.position <= first_pos_reg)
                        begin
                            res_next   = first_col_reg;
                            state_next = BK_OUT;
                        end
                        else if (job_reg.position >= rd_pos)
                        begin
                            res_next   = rd_color;
                            state_next = BK_OUT;
                        end
                        else
                        begin
                            rd_idx     = '0;
                            ph_next    = 2'd0;
                            state_next = BK_SEARCH;
                        end
                    end
                endcase
            end
            BK_SEARCH:
            begin
                // phase 0: c0 read issued; phase 1 capture c0, read i+1;
                // phase 2 test segment
                unique case (ph_reg)
                    2'd0:
                    begin
                        rd_idx  = i_reg[IDX_W-1:0];
                        ph_next = 2'd1;
                    end
                    2'd1:
                    begin
                        cap_c0  = 1'b1;
                        rd_idx  = IDX_W'(i_reg + 1'b1);
                        ph_next = 2'd2;
                    end
                    default:
                    begin
                        if (job_reg.position >= p0_reg && job_reg.position <= rd_pos)
                        begin
                            cap_c1 = 1'b1;
                            if (rd_pos == p0_reg)
                            begin
                                res_next   = c0_reg;
                                state_next = BK_OUT;
                            end
                            else
                            begin
                                div_init   = 1'b1;
                                state_next = BK_DIVIDE;
                            end
                        end
                        else if (i_reg + 2'd2 >= job_reg.count)
                        begin
                            res_next   = OPAQUE_BLACK;
                            state_next = BK_OUT;
                        end
                        else
                        begin
                            i_next  = i_reg + 1'b1;
                            rd_idx  = IDX_W'(i_reg + 1'b1);
                            ph_next = 2'd0;
                        end
                    end
                endcase
            end
            BK_DIVIDE:
            begin
                div_step = 1'b1;
                if (bit_reg == '0)
                begin
                    div_step   = 1'b0;
                    set_t      = 1'b1;
                    state_next = BK_BLEND;
                end
            end
            BK_BLEND:
            begin
                res_next   = blend_c;
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                if (!out_stall)
                    state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            i_reg     <= '0;
            ph_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            ph_reg    <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (ld_job)
            job_reg <= job;
        if (cap_first)
        begin
            first_pos_reg <= rd_pos;
            first_col_reg <= rd_color;
        end
        if (cap_c0)
        begin
            p0_reg <= rd_pos;
            c0_reg <= rd_color;
        end
        if (cap_c1)
        begin
            c1_reg <= rd_color;
            d_reg  <= rd_pos - p0_reg;
        end
        if (div_init)
        begin
            // dividend = num<<F + d/2, restoring division one bit a cycle
            quo_reg <= {num, {FRACTION_BITS{1'b0}}} + QDIV_W'((rd_pos - p0_reg) >> 1);
            rem_reg <= '0;
            bit_reg <= 6'(QDIV_W);
        end
        else if (div_step)
        begin
            if (rem_sh >= {{(QDIV_W-POS_W+1){1'b0}}, d_reg})
            begin
                rem_reg <= rem_sh - {{(QDIV_W-POS_W+1){1'b0}}, d_reg};
                quo_reg <= {quo_reg[QDIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[QDIV_W-2:0], 1'b0};
            end
            bit_reg <= bit_reg - 1'b1;
        end
        if (set_t)
        begin
            t_reg  <= (|t_full[QDIV_W-1:FRACTION_BITS+1] ||
                       t_full[FRACTION_BITS:0] > (FRACTION_BITS+1)'(1 << FRACTION_BITS)) ?
                      T_W'(1 << FRACTION_BITS) : t_full[T_W-1:0];
        end
    end

    assign idle               = (state_reg == BK_IDLE);
    assign out_valid          = (state_reg == BK_OUT);
    assign out_data.color_out = res_reg;
    assign out_data.status    = job_reg.status;
    assign out_data.stops_held = job_reg.stops_held;

endmodule

// ===== hdl/color_gradient_ramp.sv =====
// Colour gradient ramp: front table, job queue and blend back end.
// Add, clear and empty lookups pass straight to the result; other lookups are clamped
// against the first and last stops, then search segment by segment; zero-width or
// unmatched segments end there, blended results also pass the divider and the blend.
// The back end takes one item at a time; the queue holds two more, and a clear waits
// until queue and back end are empty.
// Reset clears the stop count and all control state; the table is not cleared.
module color_gradient_ramp import cgr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic               f_valid, f_stall, q_valid, q_take;
    logic               back_idle, back_busy;
    job_t               f_job, q_job;
    logic [IDX_W-1:0]   rd_idx;
    logic [POS_W-1:0]   rd_pos;
    logic [COLOR_W-1:0] rd_color;

    assign back_busy = q_valid || !back_idle;

    cgr_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_data,
        .job_valid(f_valid), .job_stall(f_stall), .job(f_job),
        .back_busy,
        .rd_idx, .rd_pos, .rd_color
    );

    cgr_queue u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_job),
        .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_job)
    );

    cgr_back u_back (
        .clk, .rst_n,
        .job_valid(q_valid), .job_take(q_take), .job(q_job),
        .idle(back_idle),
        .rd_idx, .rd_pos, .rd_color,
        .out_valid, .out_stall, .out_data
    );

endmodule
